// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment intersection core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/segit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants and flag types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segit_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int NUM_ORIENT         = 4;

   // Orientation triples: (A,B,C), (A,B,D), (C,D,A), (C,D,B).
   localparam int ORI_ABC = 0;
   localparam int ORI_ABD = 1;
   localparam int ORI_CDA = 2;
   localparam int ORI_CDB = 3;

   typedef struct packed {
      logic [NUM_ORIENT-1:0] zero;
      logic [NUM_ORIENT-1:0] positive;
   } orient_flags_type;

   // Interval checks, one per orientation triple, indexed like the triples.
   typedef struct packed {
      logic [NUM_ORIENT-1:0] hit;
   } inside_flags_type;

endpackage

// File: rtl/segit_diff_stage.sv
// ----------------------------------------------------------------------------
// Difference stage
// Forms the edge vectors of the four orientation triples and the interval
// checks from the raw coordinates, and registers them.
// ----------------------------------------------------------------------------
module segit_diff_stage #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [COORD_BITS-1:0]        a_x,
   input  logic [COORD_BITS-1:0]        a_y,
   input  logic [COORD_BITS-1:0]        b_x,
   input  logic [COORD_BITS-1:0]        b_y,
   input  logic [COORD_BITS-1:0]        c_x,
   input  logic [COORD_BITS-1:0]        c_y,
   input  logic [COORD_BITS-1:0]        d_x,
   input  logic [COORD_BITS-1:0]        d_y,
   output logic                         out_valid,
   output logic signed [COORD_BITS:0]   u_x [segit_pkg::NUM_ORIENT],
   output logic signed [COORD_BITS:0]   u_y [segit_pkg::NUM_ORIENT],
   output logic signed [COORD_BITS:0]   v_x [segit_pkg::NUM_ORIENT],
   output logic signed [COORD_BITS:0]   v_y [segit_pkg::NUM_ORIENT],
   output segit_pkg::inside_flags_type  inside_flags
);

   localparam int DIFF_BITS = COORD_BITS + 1;

   logic [COORD_BITS-1:0]        p_x [segit_pkg::NUM_ORIENT];
   logic [COORD_BITS-1:0]        p_y [segit_pkg::NUM_ORIENT];
   logic [COORD_BITS-1:0]        q_x [segit_pkg::NUM_ORIENT];
   logic [COORD_BITS-1:0]        q_y [segit_pkg::NUM_ORIENT];
   logic [COORD_BITS-1:0]        r_x [segit_pkg::NUM_ORIENT];
   logic [COORD_BITS-1:0]        r_y [segit_pkg::NUM_ORIENT];

   logic                         valid_ff;
   logic signed [DIFF_BITS-1:0]  u_x_ff [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  u_y_ff [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  v_x_ff [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  v_y_ff [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  u_x_in [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  u_y_in [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  v_x_in [segit_pkg::NUM_ORIENT];
   logic signed [DIFF_BITS-1:0]  v_y_in [segit_pkg::NUM_ORIENT];
   segit_pkg::inside_flags_type  inside_ff;
   segit_pkg::inside_flags_type  inside_in;

   // Exact difference of two signed coordinates, one bit wider.
   function automatic logic signed [DIFF_BITS-1:0] diff_of(
      input logic [COORD_BITS-1:0] hi_val,
      input logic [COORD_BITS-1:0] lo_val
   );
      return $signed({hi_val[COORD_BITS-1], hi_val}) - $signed({lo_val[COORD_BITS-1], lo_val});
   endfunction

   // True when r lies between e0 and e1, inclusive, in either order.
   function automatic logic between(
      input logic signed [COORD_BITS-1:0] e0,
      input logic signed [COORD_BITS-1:0] e1,
      input logic signed [COORD_BITS-1:0] r
   );
      return ((e0 <= r) && (r <= e1)) || ((e0 >= r) && (r >= e1));
   endfunction

   always_comb begin
      p_x[segit_pkg::ORI_ABC] = a_x;  p_y[segit_pkg::ORI_ABC] = a_y;
      q_x[segit_pkg::ORI_ABC] = b_x;  q_y[segit_pkg::ORI_ABC] = b_y;
      r_x[segit_pkg::ORI_ABC] = c_x;  r_y[segit_pkg::ORI_ABC] = c_y;
      p_x[segit_pkg::ORI_ABD] = a_x;  p_y[segit_pkg::ORI_ABD] = a_y;
      q_x[segit_pkg::ORI_ABD] = b_x;  q_y[segit_pkg::ORI_ABD] = b_y;
      r_x[segit_pkg::ORI_ABD] = d_x;  r_y[segit_pkg::ORI_ABD] = d_y;
      p_x[segit_pkg::ORI_CDA] = c_x;  p_y[segit_pkg::ORI_CDA] = c_y;
      q_x[segit_pkg::ORI_CDA] = d_x;  q_y[segit_pkg::ORI_CDA] = d_y;
      r_x[segit_pkg::ORI_CDA] = a_x;  r_y[segit_pkg::ORI_CDA] = a_y;
      p_x[segit_pkg::ORI_CDB] = c_x;  p_y[segit_pkg::ORI_CDB] = c_y;
      q_x[segit_pkg::ORI_CDB] = d_x;  q_y[segit_pkg::ORI_CDB] = d_y;
      r_x[segit_pkg::ORI_CDB] = b_x;  r_y[segit_pkg::ORI_CDB] = b_y;
   end

   always_comb begin
      for (int k = 0; k < segit_pkg::NUM_ORIENT; k++) begin
         u_x_in[k] = diff_of(q_x[k], p_x[k]);
         u_y_in[k] = diff_of(q_y[k], p_y[k]);
         v_x_in[k] = diff_of(r_x[k], p_x[k]);
         v_y_in[k] = diff_of(r_y[k], p_y[k]);
         // A vertical reference segment is checked on y instead of x.
         if (p_x[k] != q_x[k]) begin
            inside_in.hit[k] = between(p_x[k], q_x[k], r_x[k]);
         end else begin
            inside_in.hit[k] = between(p_y[k], q_y[k], r_y[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      u_x_ff    <= u_x_in;
      u_y_ff    <= u_y_in;
      v_x_ff    <= v_x_in;
      v_y_ff    <= v_y_in;
      inside_ff <= inside_in;
   end

   assign out_valid    = valid_ff;
   assign u_x          = u_x_ff;
   assign u_y          = u_y_ff;
   assign v_x          = v_x_ff;
   assign v_y          = v_y_ff;
   assign inside_flags = inside_ff;

endmodule

// File: rtl/segit_prod_stage.sv
// ----------------------------------------------------------------------------
// Product stage
// Forms the two partial products of each orientation cross product and
// registers them.
// ----------------------------------------------------------------------------
module segit_prod_stage #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [COORD_BITS:0]        u_x [segit_pkg::NUM_ORIENT],
   input  logic signed [COORD_BITS:0]        u_y [segit_pkg::NUM_ORIENT],
   input  logic signed [COORD_BITS:0]        v_x [segit_pkg::NUM_ORIENT],
   input  logic signed [COORD_BITS:0]        v_y [segit_pkg::NUM_ORIENT],
   input  segit_pkg::inside_flags_type       in_inside,
   output logic                              out_valid,
   output logic signed [2*COORD_BITS+1:0]    prod_lhs [segit_pkg::NUM_ORIENT],
   output logic signed [2*COORD_BITS+1:0]    prod_rhs [segit_pkg::NUM_ORIENT],
   output segit_pkg::inside_flags_type       out_inside
);

   localparam int PROD_BITS = 2 * (COORD_BITS + 1);

   logic                         valid_ff;
   logic signed [PROD_BITS-1:0]  lhs_ff [segit_pkg::NUM_ORIENT];
   logic signed [PROD_BITS-1:0]  rhs_ff [segit_pkg::NUM_ORIENT];
   logic signed [PROD_BITS-1:0]  lhs_in [segit_pkg::NUM_ORIENT];
   logic signed [PROD_BITS-1:0]  rhs_in [segit_pkg::NUM_ORIENT];
   segit_pkg::inside_flags_type  inside_ff;

   always_comb begin
      for (int k = 0; k < segit_pkg::NUM_ORIENT; k++) begin
         lhs_in[k] = u_x[k] * v_y[k];
         rhs_in[k] = v_x[k] * u_y[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
      inside_ff <= in_inside;
   end

   assign out_valid  = valid_ff;
   assign prod_lhs   = lhs_ff;
   assign prod_rhs   = rhs_ff;
   assign out_inside = inside_ff;

endmodule

// File: rtl/segit_cross_stage.sv
// ----------------------------------------------------------------------------
// Cross stage
// Subtracts the partial products and registers the zero and sign flags of
// the four orientations.
// ----------------------------------------------------------------------------
module segit_cross_stage #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [2*COORD_BITS+1:0]    prod_lhs [segit_pkg::NUM_ORIENT],
   input  logic signed [2*COORD_BITS+1:0]    prod_rhs [segit_pkg::NUM_ORIENT],
   input  segit_pkg::inside_flags_type       in_inside,
   output logic                              out_valid,
   output segit_pkg::orient_flags_type       orient_flags,
   output segit_pkg::inside_flags_type       out_inside
);

   localparam int PROD_BITS  = 2 * (COORD_BITS + 1);
   localparam int CROSS_BITS = PROD_BITS + 1;

   logic signed [CROSS_BITS-1:0] cross_val [segit_pkg::NUM_ORIENT];
   logic                         valid_ff;
   segit_pkg::orient_flags_type  orient_ff;
   segit_pkg::orient_flags_type  orient_in;
   segit_pkg::inside_flags_type  inside_ff;

   always_comb begin
      for (int k = 0; k < segit_pkg::NUM_ORIENT; k++) begin
         cross_val[k] = $signed({prod_lhs[k][PROD_BITS-1], prod_lhs[k]})
                      - $signed({prod_rhs[k][PROD_BITS-1], prod_rhs[k]});
         orient_in.zero[k]     = (cross_val[k] == '0);
         orient_in.positive[k] = !cross_val[k][CROSS_BITS-1] && (cross_val[k] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      orient_ff <= orient_in;
      inside_ff <= in_inside;
   end

   assign out_valid    = valid_ff;
   assign orient_flags = orient_ff;
   assign out_inside   = inside_ff;

endmodule

// File: rtl/segment_intersection_test_core.sv
// The result strobe rises once the start transfer has passed through the difference,
// product, cross-product and decision registers, in that order.
// Throughput: one segment pair per cycle; busy never rises and the receiver
// cannot stall, so no result ever waits. The four register stages
// (differences, products, cross products, decision) each hold one pair.
// Reset (synchronous, active high) clears the valid pipeline; pairs in flight are dropped.
// ----------------------------------------------------------------------------
// Segment intersection core
// Reports whether two 2D integer line segments touch or cross, using four
// orientation cross products and collinear interval checks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test_core #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_seg1_start_x,
   input  logic [COORD_BITS-1:0] req_seg1_start_y,
   input  logic [COORD_BITS-1:0] req_seg1_end_x,
   input  logic [COORD_BITS-1:0] req_seg1_end_y,
   input  logic [COORD_BITS-1:0] req_seg2_start_x,
   input  logic [COORD_BITS-1:0] req_seg2_start_y,
   input  logic [COORD_BITS-1:0] req_seg2_end_x,
   input  logic [COORD_BITS-1:0] req_seg2_end_y,
   output logic                  rsp_valid,
   output logic                  rsp_segments_meet
);

   logic                         accept;
   logic                         diff_valid;
   logic signed [COORD_BITS:0]   u_x [segit_pkg::NUM_ORIENT];
   logic signed [COORD_BITS:0]   u_y [segit_pkg::NUM_ORIENT];
   logic signed [COORD_BITS:0]   v_x [segit_pkg::NUM_ORIENT];
   logic signed [COORD_BITS:0]   v_y [segit_pkg::NUM_ORIENT];
   segit_pkg::inside_flags_type  diff_inside;

   logic                         prod_valid;
   logic signed [2*COORD_BITS+1:0] prod_lhs [segit_pkg::NUM_ORIENT];
   logic signed [2*COORD_BITS+1:0] prod_rhs [segit_pkg::NUM_ORIENT];
   segit_pkg::inside_flags_type  prod_inside;

   logic                         cross_valid;
   segit_pkg::orient_flags_type  cross_orient;
   segit_pkg::inside_flags_type  cross_inside;

   logic                         rsp_valid_ff;
   logic                         meet_ff;
   logic                         meet_in;

   // The pipeline never stalls, so every start is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   segit_diff_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_diff (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .a_x          (req_seg1_start_x),
      .a_y          (req_seg1_start_y),
      .b_x          (req_seg1_end_x),
      .b_y          (req_seg1_end_y),
      .c_x          (req_seg2_start_x),
      .c_y          (req_seg2_start_y),
      .d_x          (req_seg2_end_x),
      .d_y          (req_seg2_end_y),
      .out_valid    (diff_valid),
      .u_x          (u_x),
      .u_y          (u_y),
      .v_x          (v_x),
      .v_y          (v_y),
      .inside_flags (diff_inside)
   );

   segit_prod_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_prod (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (diff_valid),
      .u_x        (u_x),
      .u_y        (u_y),
      .v_x        (v_x),
      .v_y        (v_y),
      .in_inside  (diff_inside),
      .out_valid  (prod_valid),
      .prod_lhs   (prod_lhs),
      .prod_rhs   (prod_rhs),
      .out_inside (prod_inside)
   );

   segit_cross_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (prod_valid),
      .prod_lhs     (prod_lhs),
      .prod_rhs     (prod_rhs),
      .in_inside    (prod_inside),
      .out_valid    (cross_valid),
      .orient_flags (cross_orient),
      .out_inside   (cross_inside)
   );

   // Collinear cases are settled first, in triple order; otherwise each
   // segment must straddle the line of the other.
   always_comb begin
      priority if (cross_orient.zero[segit_pkg::ORI_ABC]) begin
         meet_in = cross_inside.hit[segit_pkg::ORI_ABC]
                || (cross_orient.zero[segit_pkg::ORI_ABD]
                    && (cross_inside.hit[segit_pkg::ORI_CDA]
                        || cross_inside.hit[segit_pkg::ORI_CDB]));
      end else if (cross_orient.zero[segit_pkg::ORI_ABD]) begin
         meet_in = cross_inside.hit[segit_pkg::ORI_ABD];
      end else if (cross_orient.zero[segit_pkg::ORI_CDA]) begin
         meet_in = cross_inside.hit[segit_pkg::ORI_CDA]
                || (cross_orient.zero[segit_pkg::ORI_CDB]
                    && (cross_inside.hit[segit_pkg::ORI_ABC]
                        || cross_inside.hit[segit_pkg::ORI_ABD]));
      end else if (cross_orient.zero[segit_pkg::ORI_CDB]) begin
         meet_in = cross_inside.hit[segit_pkg::ORI_CDB];
      end else begin
         meet_in = (cross_orient.positive[segit_pkg::ORI_ABC]
                    != cross_orient.positive[segit_pkg::ORI_ABD])
                && (cross_orient.positive[segit_pkg::ORI_CDA]
                    != cross_orient.positive[segit_pkg::ORI_CDB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cross_valid;
      end
   end

   always_ff @(posedge clock) begin
      meet_ff <= meet_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segments_meet = meet_ff;

   `ASSERT_IMPLIES(a_rsp_follows_transfer, clock, reset, rsp_valid, $past(accept, 4))
   `ASSERT_IMPLIES(a_zero_not_positive, clock, reset, cross_valid,
                   (cross_orient.zero & cross_orient.positive) == '0)
   `ASSERT_NEXT(a_cross_feeds_rsp, clock, reset, cross_valid, rsp_valid)

endmodule
